// ===== hdl/gfst_pkg.sv =====
// ----------------------------------------------------------------------------
// gfst_pkg
// shared types and constants of the grid frame stability tracker
// ----------------------------------------------------------------------------
package gfst_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;

    localparam int CELL_W   = 8;
    localparam int FRAME_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] REQUIRED_RESET = 8'd3;

    typedef enum logic [OP_W-1:0] {
        OP_CELL  = 2'd0,
        OP_RESET = 2'd1,
        OP_DROP  = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_READY   = 2'd2
    } t_status;

    // request in the compare stage
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic              first;
        logic              wrote;
        logic              stale;
        logic              complete;
        logic              last;
        logic              acc;
        logic [CELL_W-1:0] cell_val;
    } t_stage;

endpackage

// ===== hdl/gfst_if.sv =====
// ----------------------------------------------------------------------------
// gfst channel interfaces
// valid/ready channels for cell requests, results and configuration
// ----------------------------------------------------------------------------
interface gfst_in_if;
    logic                          valid;
    logic                          ready;
    logic [gfst_pkg::OP_W-1:0]     opcode;
    logic [gfst_pkg::FRAME_W-1:0]  frame_number;
    logic [gfst_pkg::CELL_W-1:0]   cell_value;
    logic                          last_cell;

    modport source (output valid, opcode, frame_number, cell_value, last_cell, input ready);
    modport sink   (input valid, opcode, frame_number, cell_value, last_cell, output ready);
endinterface

interface gfst_out_if;
    logic                           valid;
    logic                           ready;
    logic [gfst_pkg::STATUS_W-1:0]  status;
    logic [gfst_pkg::COUNT_W-1:0]   stable_frames;

    modport source (output valid, status, stable_frames, input ready);
    modport sink   (input valid, status, stable_frames, output ready);
endinterface

interface gfst_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gfst_pkg::COUNT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/grid_frame_stability_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// grid_frame_stability_tracker_unit
// debounces a streamed character grid frame by frame against a candidate store
// ----------------------------------------------------------------------------
// result: the last cell is held in the compare stage register, and the result register loads as it retires
// throughput: one request per cycle, set by the single read-modify-write of the
//   candidate ram per cell; input stalls only while a result waits behind a full output
// reset: synchronous active low, clears counters, flags and the ram fill count;
//   entries at or past the fill count read as zero, so the store is empty at once
// ----------------------------------------------------------------------------
module grid_frame_stability_tracker_unit #(
    parameter int GRID_ROWS = gfst_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gfst_pkg::GRID_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfst_cfg_if.sink    i_cfg,
    gfst_in_if.sink     i_in,
    gfst_out_if.source  o_out
);
    import gfst_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int PW    = $clog2(CELLS + 1);
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [COUNT_W-1:0]  r_required;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_fill, n_fill;
    logic                r_frame_acc, n_frame_acc;
    logic [FRAME_W-1:0]  r_last_id, n_last_id;
    t_stage              r_s2, n_s2;
    logic                r_mis, n_mis;
    logic                r_cand_valid, n_cand_valid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [COUNT_W-1:0]  r_out_count;

    logic                in_fire, advance, blocked, s2_result, retire;
    logic                acc_now, wrote_now, mis_now;
    logic [CELL_W-1:0]   old_cell;
    logic [CELL_W-1:0]   old_val;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_required <= REQUIRED_RESET;
        end else if (i_cfg.valid) begin
            r_required <= i_cfg.data;
        end
    end

    // flow control
    assign s2_result = r_s2.valid && (r_s2.op == OP_CELL) && r_s2.last;
    assign blocked   = s2_result && r_out_valid && !o_out.ready;
    assign advance   = !blocked;
    assign retire    = r_s2.valid && advance;
    assign in_fire   = i_in.valid && advance;
    assign i_in.ready = advance;

    // stage 1: frame tracking and ram access
    always_comb begin
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_frame_acc = r_frame_acc;
        n_last_id   = r_last_id;
        n_s2        = '0;
        acc_now     = (r_pos == '0)
                      ? ((i_in.frame_number != '0) && (i_in.frame_number != r_last_id))
                      : r_frame_acc;
        wrote_now   = acc_now && (r_pos < PW'(CELLS));
        if (in_fire) begin
            case (i_in.opcode)
                OP_RESET: begin
                    n_last_id   = i_in.frame_number;
                    n_pos       = '0;
                    n_fill      = '0;
                    n_frame_acc = 1'b0;
                    n_s2.valid  = 1'b1;
                    n_s2.op     = i_in.opcode;
                end
                OP_DROP: begin
                    n_pos       = '0;
                    n_frame_acc = 1'b0;
                    n_s2.valid  = 1'b1;
                    n_s2.op     = i_in.opcode;
                end
                OP_CELL: begin
                    if ((r_pos == '0) && acc_now) begin
                        n_last_id = i_in.frame_number;
                    end
                    if (wrote_now && (r_pos >= r_fill)) begin
                        n_fill = r_pos + PW'(1);
                    end
                    if (i_in.last_cell) begin
                        n_pos       = '0;
                        n_frame_acc = 1'b0;
                    end else begin
                        n_frame_acc = acc_now;
                        if (r_pos < PW'(CELLS)) begin
                            n_pos = r_pos + PW'(1);
                        end
                    end
                    n_s2.valid    = 1'b1;
                    n_s2.op       = i_in.opcode;
                    n_s2.first    = (r_pos == '0);
                    n_s2.wrote    = wrote_now;
                    n_s2.stale    = (r_pos >= r_fill);
                    n_s2.complete = (r_pos >= PW'(CELLS - 1));
                    n_s2.last     = i_in.last_cell;
                    n_s2.acc      = acc_now;
                    n_s2.cell_val = i_in.cell_value;
                end
                default: begin
                    n_s2 = '0;
                end
            endcase
        end
    end

    gfst_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cand_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (i_in.opcode == OP_CELL) && wrote_now),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_in.cell_value),
        .i_re    (advance),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (old_cell)
    );

    // entries at or past the fill count hold no data since the last clear
    assign old_val = r_s2.stale ? '0 : old_cell;

    // stage 2: compare and stability count
    always_comb begin
        n_cand_valid = r_cand_valid;
        n_count      = r_count;
        n_mis        = r_mis;
        n_status     = ST_NONE;
        mis_now      = (r_s2.first ? 1'b0 : r_mis)
                       || (r_s2.wrote && (old_val != r_s2.cell_val));
        if (retire) begin
            case (r_s2.op)
                OP_RESET, OP_DROP: begin
                    n_cand_valid = 1'b0;
                    n_count      = '0;
                    n_mis        = 1'b0;
                end
                OP_CELL: begin
                    if (r_s2.last) begin
                        n_mis = 1'b0;
                        if (r_s2.acc) begin
                            if (!r_cand_valid || mis_now || !r_s2.complete) begin
                                n_cand_valid = 1'b1;
                                n_count      = COUNT_W'(1);
                            end else if (r_count < r_required) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                            n_status = (n_count >= r_required) ? ST_READY : ST_PENDING;
                        end
                    end else begin
                        n_mis = mis_now;
                    end
                end
                default: begin
                    n_mis = r_mis;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_fill       <= '0;
            r_frame_acc  <= 1'b0;
            r_last_id    <= '0;
            r_s2         <= '0;
            r_mis        <= 1'b0;
            r_cand_valid <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_fill       <= n_fill;
            r_frame_acc  <= n_frame_acc;
            r_last_id    <= n_last_id;
            if (advance) begin
                r_s2 <= n_s2;
            end
            r_mis        <= n_mis;
            r_cand_valid <= n_cand_valid;
            r_count      <= n_count;
            if (retire && s2_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (retire && s2_result) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.stable_frames = r_out_count;

endmodule

// ===== hdl/gfst_ram.sv =====
// ----------------------------------------------------------------------------
// gfst_ram
// simple dual port ram, one write and one registered read, read-old on collision
// ----------------------------------------------------------------------------
module gfst_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/gfst_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfst_result_checker
// watches the cell, config and result channels of the stability tracker,
// predicts the status of every closed frame and compares it with the result
// ----------------------------------------------------------------------------
module gfst_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    gfst_cfg_if  i_cfg,
    gfst_in_if   i_in,
    gfst_out_if  i_out,
    output int   o_err_cnt,
    output int   o_pending,
    output int   o_result_cnt,
    output int   o_ready_cnt
);
    import gfst_pkg::*;

    localparam int GRID_CELLS = GRID_ROWS_DEF * GRID_COLS_DEF;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] stable;
    } t_grid_result;

    logic [CELL_W-1:0]  cand_mem [GRID_CELLS];
    int unsigned        cell_pos;
    logic               frame_taken;
    logic               diff_seen;
    logic               cand_ok;
    logic [COUNT_W-1:0] stable_cnt;
    logic [COUNT_W-1:0] required;
    logic [FRAME_W-1:0] held_id;
    t_grid_result       status_q [$];

    task automatic end_frame();
        cell_pos    = 0;
        frame_taken = 1'b0;
        diff_seen   = 1'b0;
    endtask

    task automatic predict_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fn,
                                   input logic [CELL_W-1:0] cv, input logic lc);
        int unsigned  pos;
        t_grid_result res;
        pos = cell_pos;
        case (op)
            OP_RESET: begin
                foreach (cand_mem[i]) cand_mem[i] = '0;
                held_id    = fn;
                cand_ok    = 1'b0;
                stable_cnt = '0;
                end_frame();
            end
            OP_DROP: begin
                cand_ok    = 1'b0;
                stable_cnt = '0;
                end_frame();
            end
            OP_CELL: begin
                if (pos == 0) begin
                    diff_seen   = 1'b0;
                    frame_taken = (fn != '0) && (fn != held_id);
                    if (frame_taken) held_id = fn;
                end
                if (frame_taken && pos < GRID_CELLS) begin
                    if (cand_mem[pos] != cv) diff_seen = 1'b1;
                    cand_mem[pos] = cv;
                end
                if (!lc) begin
                    if (cell_pos < GRID_CELLS) cell_pos++;
                end else begin
                    if (frame_taken) begin
                        if (!cand_ok || diff_seen || pos < GRID_CELLS - 1) begin
                            cand_ok    = 1'b1;
                            stable_cnt = 8'd1;
                        end else if (stable_cnt < required) begin
                            stable_cnt = stable_cnt + 8'd1;
                        end
                        res.status = (stable_cnt >= required) ? ST_READY : ST_PENDING;
                    end else begin
                        res.status = ST_NONE;
                    end
                    res.stable = stable_cnt;
                    status_q.push_back(res);
                    end_frame();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_grid_result want;
        if (!i_rst_n) begin
            foreach (cand_mem[i]) cand_mem[i] = '0;
            end_frame();
            cand_ok      = 1'b0;
            stable_cnt   = '0;
            held_id      = '0;
            required     = REQUIRED_RESET;
            o_err_cnt    = 0;
            o_result_cnt = 0;
            o_ready_cnt  = 0;
            status_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                o_result_cnt++;
                if (status_q.size() == 0) begin
                    o_err_cnt++;
                    $display("%0t: unexpected result, expected none, actual status %0d stable %0d",
                             $time, i_out.status, i_out.stable_frames);
                end else begin
                    want = status_q.pop_front();
                    if (want.status == ST_READY) o_ready_cnt++;
                    if (i_out.status !== want.status) begin
                        o_err_cnt++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_out.status);
                    end
                    if (i_out.stable_frames !== want.stable) begin
                        o_err_cnt++;
                        $display("%0t: stable_frames mismatch, expected %0d, actual %0d",
                                 $time, want.stable, i_out.stable_frames);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) required = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                predict_request(i_in.opcode, i_in.frame_number, i_in.cell_value, i_in.last_cell);
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== sim/grid_frame_stability_tracker_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_frame_stability_tracker_unit_test
// feeds cell, opcode and threshold write requests to the tracker with bursty
// sending and a stalling receiver; a checker beside the block predicts and
// compares every result while this module makes stimulus and the verdict
// ----------------------------------------------------------------------------
module grid_frame_stability_tracker_unit_test;
    import gfst_pkg::*;

    localparam int GRID_CELLS    = GRID_ROWS_DEF * GRID_COLS_DEF;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 8;
    localparam int TARGET_ITEMS  = 1250;

    logic i_clk;
    logic i_rst_n;

    gfst_cfg_if cfg_ch ();
    gfst_in_if  cell_ch ();
    gfst_out_if res_ch ();

    int err_cnt;
    int pending_cnt;
    int result_cnt;
    int ready_cnt;

    int sent_cnt       = 0;
    int closed_frames  = 0;
    int burst_left     = 0;
    int cfg_writes     = 0;
    int stall_req_cnt  = 0;
    int stall_done_cnt = 0;

    logic [FRAME_W-1:0] last_id;
    logic [CELL_W-1:0]  content [GRID_CELLS];

    grid_frame_stability_tracker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (cell_ch),
        .o_out   (res_ch)
    );

    gfst_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (cell_ch),
        .i_out        (res_ch),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending_cnt),
        .o_result_cnt (result_cnt),
        .o_ready_cnt  (ready_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("grid_frame_stability_tracker_unit verification failed");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : receiver
        int mode;
        int mode_left;
        int period;
        mode = 0;
        mode_left = 0;
        period = 4;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_done_cnt != stall_req_cnt) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                stall_done_cnt++;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 200);
                    period = $urandom_range(2, 9);
                end
                mode_left--;
                if (mode == 0) begin
                    res_ch.ready <= 1'b1;
                end else if (mode == 1) begin
                    res_ch.ready <= ($urandom_range(0, 3) != 0);
                end else if (mode == 2) begin
                    res_ch.ready <= ((mode_left % period) != 0);
                end else begin
                    res_ch.ready <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    task automatic push_request(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fn,
                                input logic [CELL_W-1:0] cv, input logic lc);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_ch.valid        <= 1'b1;
        cell_ch.opcode       <= op;
        cell_ch.frame_number <= fn;
        cell_ch.cell_value   <= cv;
        cell_ch.last_cell    <= lc;
        do @(posedge i_clk); while (cell_ch.ready !== 1'b1);
        sent_cnt++;
        if (op == OP_CELL && lc) closed_frames++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_required(input logic [COUNT_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [FRAME_W-1:0] fresh_id();
        logic [FRAME_W-1:0] id;
        do id = $urandom(); while (id == '0 || id == last_id);
        return id;
    endfunction

    task automatic send_frame(input logic [FRAME_W-1:0] id, input int len, input bit follow,
                              input bit close);
        logic [FRAME_W-1:0] fn;
        logic [CELL_W-1:0]  cv;
        if (id != '0 && id != last_id) last_id = id;
        for (int i = 0; i < len; i++) begin
            fn = (i == 0 || $urandom_range(0, 7) != 0) ? id : $urandom();
            cv = (follow && i < GRID_CELLS) ? content[i] : 8'($urandom_range(0, 255));
            if (i > 0 && $urandom_range(0, 39) == 0) begin
                push_request(OP_SPARE, $urandom(), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
            push_request(OP_CELL, fn, cv, close && (i == len - 1));
        end
    endtask

    task automatic send_run(input int frames, input int mutate_at);
        int extra;
        int k;
        for (int f = 0; f < frames; f++) begin
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            if (f == mutate_at) begin
                k = $urandom_range(0, GRID_CELLS - 1);
                content[k] = content[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            send_frame(fresh_id(), GRID_CELLS + extra, 1'b1, 1'b1);
        end
    endtask

    task automatic short_scenario();
        int pick;
        logic [FRAME_W-1:0] id;
        pick = $urandom_range(0, 11);
        if (pick < 5) begin
            send_frame(fresh_id(), $urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 7) begin
            id = ($urandom_range(0, 1) != 0) ? '0 : last_id;
            send_frame(id, $urandom_range(1, 6), 1'b0, 1'b1);
        end else if (pick == 7) begin
            case ($urandom_range(0, 3))
                0: id = '0;
                1: id = last_id;
                default: id = $urandom();
            endcase
            push_request(OP_RESET, id, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            last_id = id;
        end else if (pick == 8) begin
            push_request(OP_DROP, $urandom(), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
        end else if (pick == 9) begin
            // frame cut short by an abort
            send_frame(fresh_id(), $urandom_range(1, 6), 1'($urandom_range(0, 1)), 1'b0);
            if ($urandom_range(0, 1) != 0) begin
                id = $urandom();
                push_request(OP_RESET, id, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                last_id = id;
            end else begin
                push_request(OP_DROP, $urandom(), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
        end else if (pick == 10) begin
            push_request(OP_SPARE, $urandom(), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
        end else begin
            send_frame(fresh_id(), $urandom_range(13, 40), 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    task automatic mix_short(input int min_items, input int min_results);
        int sent0;
        int closed0;
        sent0 = sent_cnt;
        closed0 = closed_frames;
        while (sent_cnt - sent0 < min_items || closed_frames - closed0 < min_results) begin
            short_scenario();
        end
    endtask

    initial begin : stimulus
        int run_len;
        cell_ch.valid        = 1'b0;
        cell_ch.opcode       = OP_CELL;
        cell_ch.frame_number = '0;
        cell_ch.cell_value   = '0;
        cell_ch.last_cell    = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        i_rst_n              = 1'b0;
        last_id              = '0;
        foreach (content[i]) content[i] = 8'($urandom_range(0, 255));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests, store cleared by the reset opcode first
        push_request(OP_RESET, '1, 8'h00, 1'b1);
        last_id = '1;
        push_request(OP_CELL, '1, 8'hFF, 1'b1);
        push_request(OP_CELL, '0, 8'h80, 1'b1);
        push_request(OP_CELL, 32'd1, 8'h00, 1'b1);
        last_id = 32'd1;
        push_request(OP_CELL, 32'd2, 8'hFF, 1'b0);
        last_id = 32'd2;
        push_request(OP_SPARE, '1, 8'hFF, 1'b1);
        push_request(OP_CELL, '1, 8'h5A, 1'b1);
        push_request(OP_CELL, 32'd3, 8'hA5, 1'b0);
        last_id = 32'd3;
        push_request(OP_DROP, 32'd3, 8'h00, 1'b1);
        push_request(OP_CELL, 32'd3, 8'h11, 1'b1);
        push_request(OP_CELL, 32'd4, 8'h22, 1'b0);
        push_request(OP_RESET, 32'd4, 8'h33, 1'b0);
        last_id = 32'd4;
        push_request(OP_CELL, 32'd4, 8'h44, 1'b1);
        push_request(OP_CELL, 32'h8000_0000, 8'h7F, 1'b1);
        push_request(OP_CELL, 32'h7FFF_FFFF, 8'h01, 1'b1);
        push_request(OP_DROP, '0, 8'hC3, 1'b0);
        push_request(OP_RESET, '0, 8'h3C, 1'b0);
        last_id = '0;
        push_request(OP_CELL, '0, 8'hF0, 1'b1);
        push_request(OP_CELL, 32'd5, 8'h0F, 1'b1);
        last_id = 32'd5;

        write_required(8'd2);
        mix_short(30, 4);
        run_len = 3;
        send_run(run_len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, run_len - 1) : -1);

        // stability chain carries over into a far higher threshold
        write_required(8'd255);
        send_run(1, -1);
        mix_short(30, 4);

        write_required(8'd0);
        mix_short(30, 4);

        write_required(8'd1);
        stall_req_cnt++;
        repeat (40) send_frame(fresh_id(), 1, 1'b0, 1'b1);
        mix_short(30, 4);

        write_required(8'($urandom_range(0, 255)));
        mix_short((sent_cnt < TARGET_ITEMS) ? TARGET_ITEMS - sent_cnt : 30, 4);

        settle();
        $display("%0d requests sent across %0d threshold settings (0 and 255 among them)",
                 sent_cnt, cfg_writes);
        $display("%0d results checked, %0d ready, long hold-off and idle config writes done",
                 result_cnt, ready_cnt);
        if (err_cnt == 0 && pending_cnt == 0) begin
            $display("grid_frame_stability_tracker_unit verification clean");
        end else begin
            $display("grid_frame_stability_tracker_unit verification failed");
        end
        $finish;
    end

endmodule
